>>> hw/rtl/ppvrm_pkg.sv
// Shared constants, widths and controller/datapath command and status types for the
// pulse peak/valley rate meter. No dependencies.
`default_nettype none

package ppvrm_pkg;

   localparam int HISTORY_DEPTH = 9;

   localparam int SAMPLE_W = 16;
   localparam int TIME_W   = 32;
   localparam int RATE_W   = 16;
   localparam int SWING_W  = 17;

   // Running sum of the rate history.
   localparam int SUM_W = RATE_W + $clog2(HISTORY_DEPTH);
   // Dividend width of the rate divider: 60000 fits a rate.
   localparam int DIV_W = RATE_W;

   localparam logic [DIV_W-1:0] MS_PER_MINUTE = DIV_W'(60000);

   // Mean by reciprocal multiplication: floor(sum * MEAN_RECIP / 2^MEAN_SHIFT)
   // equals sum / HISTORY_DEPTH for every sum below 2^SUM_W.
   localparam int MEAN_SHIFT = SUM_W + $clog2(HISTORY_DEPTH);
   localparam int RECIP_W    = SUM_W + 1;
   localparam logic [RECIP_W-1:0] MEAN_RECIP =
      RECIP_W'(((64'd1 << MEAN_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

   typedef struct packed {
      logic capture;    // latch the accepted input beat
      logic eval;       // classify sample, update slope and swing state
      logic rate_go;    // start 60000 / period
      logic rate_load;  // take rate, shift history, update sum
      logic mean_load;  // take mean from the reciprocal product
      logic out_load;   // load the result register
   } ppvrm_cmd_type;

   typedef struct packed {
      logic rate_event; // valley that closes a period
      logic div_done;   // divider finished this cycle
   } ppvrm_sts_type;

endpackage

`default_nettype wire

>>> hw/rtl/pulse_peak_valley_rate_meter_unit.sv
// Top level of the pulse peak/valley rate meter: controller plus datapath.
// Depends on ppvrm_pkg, ppvrm_ctrl, ppvrm_dp.
//
// One result beat per input beat. The block takes one sample at a time:
// a sample that closes no beat period goes from acceptance through the
// evaluate and output states to the result register; a valley that closes
// a period also runs the serial divider for 60000 / period (a quotient bit
// for each of the DIV_W dividend bits, then done) and takes the history
// mean by reciprocal multiplication in the mean state. Either path waits in
// the output state while the previous result beat still waits downstream.
// The result register lets the next sample be accepted while a result waits
// downstream. History and running sum reset to zero.
`default_nettype none

module pulse_peak_valley_rate_meter_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [ppvrm_pkg::SAMPLE_W-1:0]   req_sample,
   input  wire logic [ppvrm_pkg::TIME_W-1:0]            req_time_ms,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [ppvrm_pkg::RATE_W-1:0]                 rsp_rate_bpm,
   output logic [ppvrm_pkg::RATE_W-1:0]                 rsp_mean_rate_bpm,
   output logic signed [ppvrm_pkg::SWING_W-1:0]         rsp_swing,
   output logic signed [ppvrm_pkg::SAMPLE_W-1:0]        rsp_midpoint,
   output logic                                        rsp_valley_seen,
   output logic                                        rsp_peak_seen
);
   import ppvrm_pkg::*;

   ppvrm_cmd_type cmd;
   ppvrm_sts_type sts;

   ppvrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   ppvrm_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_sample        (req_sample),
      .req_time_ms       (req_time_ms),
      .rsp_rate_bpm      (rsp_rate_bpm),
      .rsp_mean_rate_bpm (rsp_mean_rate_bpm),
      .rsp_swing         (rsp_swing),
      .rsp_midpoint      (rsp_midpoint),
      .rsp_valley_seen   (rsp_valley_seen),
      .rsp_peak_seen     (rsp_peak_seen)
   );

endmodule

`default_nettype wire

>>> hw/rtl/ppvrm_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on ppvrm_pkg.
`default_nettype none

module ppvrm_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [ppvrm_pkg::DIV_W-1:0]  dividend,
   input  wire logic [ppvrm_pkg::TIME_W-1:0] divisor,
   output logic                             done,
   output logic [ppvrm_pkg::RATE_W-1:0]      quotient
);
   import ppvrm_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [TIME_W-1:0] dvs_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [TIME_W:0]   trial;
   logic [TIME_W:0]   diff;

   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      if (!diff[TIME_W]) begin
         rem_in = diff[TIME_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], 1'b1};
      end else begin
         rem_in = trial[TIME_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], 1'b0};
      end
   end

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff[RATE_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/ppvrm_dp.sv
// Datapath: sample history, peak/valley detection, rate history with
// running sum, swing/midpoint, result register. Depends on ppvrm_pkg, ppvrm_div.
`default_nettype none

module ppvrm_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ppvrm_pkg::ppvrm_cmd_type           cmd,
   output ppvrm_pkg::ppvrm_sts_type                sts,
   input  wire logic signed [ppvrm_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic [ppvrm_pkg::TIME_W-1:0]       req_time_ms,
   output logic [ppvrm_pkg::RATE_W-1:0]            rsp_rate_bpm,
   output logic [ppvrm_pkg::RATE_W-1:0]            rsp_mean_rate_bpm,
   output logic signed [ppvrm_pkg::SWING_W-1:0]    rsp_swing,
   output logic signed [ppvrm_pkg::SAMPLE_W-1:0]   rsp_midpoint,
   output logic                                   rsp_valley_seen,
   output logic                                   rsp_peak_seen
);
   import ppvrm_pkg::*;

   // input beat
   logic [SAMPLE_W-1:0] smp_ff;
   logic [TIME_W-1:0]   tms_ff;

   // tracking state
   logic [SAMPLE_W-1:0] prev_ff, prev_in;
   logic [SAMPLE_W-1:0] prev2_ff, prev2_in;
   logic                psv_ff, psv_in;
   logic                vsp_ff, vsp_in;
   logic [TIME_W-1:0]   start_ff, start_in;
   logic [SAMPLE_W-1:0] valley_ff, valley_in;
   logic [SWING_W-1:0]  swing_ff, swing_in;
   logic [SAMPLE_W-1:0] mid_ff, mid_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [RATE_W-1:0]   mean_ff, mean_in;
   logic [RATE_W-1:0]   hist_ff [HISTORY_DEPTH];
   logic [RATE_W-1:0]   hist_in [HISTORY_DEPTH];
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                vflag_ff, vflag_in;
   logic                pflag_ff, pflag_in;

   // result register
   logic [RATE_W-1:0]   out_rate_ff;
   logic [RATE_W-1:0]   out_mean_ff;
   logic [SWING_W-1:0]  out_swing_ff;
   logic [SAMPLE_W-1:0] out_mid_ff;
   logic                out_valley_ff;
   logic                out_peak_ff;

   logic [SAMPLE_W:0]   d_now;
   logic [SAMPLE_W:0]   d_before;
   logic                valley;
   logic                peak;
   logic [TIME_W-1:0]   period;
   logic [TIME_W-1:0]   rate_divisor;
   logic [SWING_W-1:0]  swing_calc;
   logic [SAMPLE_W:0]   pair_sum;
   logic [SAMPLE_W:0]   pair_adj;
   logic [SUM_W+RECIP_W-1:0] mean_prod;
   logic                div_done;
   logic [RATE_W-1:0]   div_quotient;

   always_comb begin
      d_now    = {smp_ff[SAMPLE_W-1], smp_ff} - {prev_ff[SAMPLE_W-1], prev_ff};
      d_before = {prev_ff[SAMPLE_W-1], prev_ff} - {prev2_ff[SAMPLE_W-1], prev2_ff};
      valley   = !d_now[SAMPLE_W] && (d_now != '0)
                 && (d_before[SAMPLE_W] || (d_before == '0));
      peak     = d_now[SAMPLE_W] && !d_before[SAMPLE_W];

      period       = tms_ff - start_ff;
      rate_divisor = (period == '0) ? TIME_W'(1) : period;

      swing_calc = {prev_ff[SAMPLE_W-1], prev_ff} - {valley_ff[SAMPLE_W-1], valley_ff};
      pair_sum   = {prev_ff[SAMPLE_W-1], prev_ff} + {valley_ff[SAMPLE_W-1], valley_ff};
      // round toward zero before the halving shift
      pair_adj   = pair_sum + (SAMPLE_W+1)'(pair_sum[SAMPLE_W]);

      mean_prod  = sum_ff * MEAN_RECIP;
   end

   ppvrm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.rate_go),
      .dividend (MS_PER_MINUTE),
      .divisor  (rate_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign sts = '{rate_event: valley && psv_ff, div_done: div_done};

   always_comb begin
      prev_in   = prev_ff;
      prev2_in  = prev2_ff;
      psv_in    = psv_ff;
      vsp_in    = vsp_ff;
      start_in  = start_ff;
      valley_in = valley_ff;
      swing_in  = swing_ff;
      mid_in    = mid_ff;
      rate_in   = rate_ff;
      mean_in   = mean_ff;
      sum_in    = sum_ff;
      vflag_in  = vflag_ff;
      pflag_in  = pflag_ff;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         hist_in[i] = hist_ff[i];
      end

      if (cmd.eval) begin
         vflag_in = valley;
         pflag_in = peak;
         if (valley) begin
            if (psv_ff) begin
               psv_in   = 1'b0;
               start_in = tms_ff;
            end
            valley_in = prev_ff;
            vsp_in    = 1'b1;
         end
         if (peak) begin
            psv_in = 1'b1;
            if (vsp_ff) begin
               swing_in = swing_calc;
               mid_in   = pair_adj[SAMPLE_W:1];
               vsp_in   = 1'b0;
            end
         end
         prev2_in = prev_ff;
         prev_in  = smp_ff;
      end

      if (cmd.rate_load) begin
         rate_in    = div_quotient;
         hist_in[0] = div_quotient;
         for (int i = 1; i < HISTORY_DEPTH; i++) begin
            hist_in[i] = hist_ff[i-1];
         end
         // drop the oldest rate, add the new one
         sum_in = sum_ff - SUM_W'(hist_ff[HISTORY_DEPTH-1]) + SUM_W'(div_quotient);
      end

      if (cmd.mean_load) begin
         mean_in = mean_prod[MEAN_SHIFT +: RATE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         prev2_ff  <= '0;
         psv_ff    <= 1'b0;
         vsp_ff    <= 1'b0;
         start_ff  <= '0;
         valley_ff <= '0;
         swing_ff  <= '0;
         mid_ff    <= '0;
         rate_ff   <= '0;
         mean_ff   <= '0;
         sum_ff    <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         prev_ff   <= prev_in;
         prev2_ff  <= prev2_in;
         psv_ff    <= psv_in;
         vsp_ff    <= vsp_in;
         start_ff  <= start_in;
         valley_ff <= valley_in;
         swing_ff  <= swing_in;
         mid_ff    <= mid_in;
         rate_ff   <= rate_in;
         mean_ff   <= mean_in;
         sum_ff    <= sum_in;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      vflag_ff <= vflag_in;
      pflag_ff <= pflag_in;
      if (cmd.capture) begin
         smp_ff <= req_sample;
         tms_ff <= req_time_ms;
      end
      if (cmd.out_load) begin
         out_rate_ff   <= rate_ff;
         out_mean_ff   <= mean_ff;
         out_swing_ff  <= swing_ff;
         out_mid_ff    <= mid_ff;
         out_valley_ff <= vflag_ff;
         out_peak_ff   <= pflag_ff;
      end
   end

   assign rsp_rate_bpm      = out_rate_ff;
   assign rsp_mean_rate_bpm = out_mean_ff;
   assign rsp_swing         = out_swing_ff;
   assign rsp_midpoint      = out_mid_ff;
   assign rsp_valley_seen   = out_valley_ff;
   assign rsp_peak_seen     = out_peak_ff;

endmodule

`default_nettype wire

>>> hw/rtl/ppvrm_ctrl.sv
// Controller state machine: sequences capture, evaluation, the rate divide,
// the mean and the result register. Depends on ppvrm_pkg.
`default_nettype none

module ppvrm_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output ppvrm_pkg::ppvrm_cmd_type      cmd,
   input  wire ppvrm_pkg::ppvrm_sts_type sts
);
   import ppvrm_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EVAL = 3'd1;
   localparam logic [2:0] S_RATE = 3'd2;
   localparam logic [2:0] S_MEAN = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.rate_event) begin
               cmd.rate_go = 1'b1;
               state_in    = S_RATE;
            end else begin
               state_in = S_OUT;
            end
         end
         S_RATE: begin
            if (sts.div_done) begin
               cmd.rate_load = 1'b1;
               state_in      = S_MEAN;
            end
         end
         S_MEAN: begin
            cmd.mean_load = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            // hold until the previous result beat has left
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> hw/rtl/ppvrm_checker.sv
// Port-level assertions for the pulse peak/valley rate meter, bound to the
// top level. Depends on ppvrm_pkg and pulse_peak_valley_rate_meter_unit.
`default_nettype none

module ppvrm_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_stall,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_stall,
   input wire logic [ppvrm_pkg::RATE_W-1:0]          rsp_rate_bpm,
   input wire logic [ppvrm_pkg::RATE_W-1:0]          rsp_mean_rate_bpm,
   input wire logic signed [ppvrm_pkg::SWING_W-1:0]  rsp_swing,
   input wire logic signed [ppvrm_pkg::SAMPLE_W-1:0] rsp_midpoint,
   input wire logic                                 rsp_valley_seen,
   input wire logic                                 rsp_peak_seen
);
   import ppvrm_pkg::*;

   // result channel is empty right after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat valid right after reset");

   // one sample in flight: stall the input the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second sample accepted back to back");

   // a sample cannot be both a valley and a peak
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_valley_seen && rsp_peak_seen))
      else $error("valley and peak flagged on one beat");

   // rates never exceed one beat per millisecond
   a_rate_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rate_bpm <= RATE_W'(60000)) && (rsp_mean_rate_bpm <= RATE_W'(60000)))
      else $error("rate out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_rate_bpm)
         && $stable(rsp_mean_rate_bpm) && $stable(rsp_swing) && $stable(rsp_midpoint)
         && $stable(rsp_valley_seen) && $stable(rsp_peak_seen))
      else $error("stalled result beat changed");

endmodule

bind pulse_peak_valley_rate_meter_unit ppvrm_checker u_ppvrm_checker (.*);

`default_nettype wire

>>> tb/tb_pulse_peak_valley_rate_meter_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for pulse_peak_valley_rate_meter_unit: directed edge cases,
// shaped pulse waveforms and noise, with random request gaps and result stalls.
// Depends on ppvrm_pkg and the RTL of the unit.

module tb_pulse_peak_valley_rate_meter_unit;
   import ppvrm_pkg::*;

   typedef struct packed {
      logic [RATE_W-1:0]          rate;
      logic [RATE_W-1:0]          mean;
      logic signed [SWING_W-1:0]  swing;
      logic signed [SAMPLE_W-1:0] midpoint;
      logic                       valley;
      logic                       peak;
   } meter_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic [TIME_W-1:0]          req_time_ms = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [RATE_W-1:0]          rsp_rate_bpm;
   logic [RATE_W-1:0]          rsp_mean_rate_bpm;
   logic signed [SWING_W-1:0]  rsp_swing;
   logic signed [SAMPLE_W-1:0] rsp_midpoint;
   logic                       rsp_valley_seen;
   logic                       rsp_peak_seen;

   pulse_peak_valley_rate_meter_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .req_time_ms       (req_time_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_rate_bpm      (rsp_rate_bpm),
      .rsp_mean_rate_bpm (rsp_mean_rate_bpm),
      .rsp_swing         (rsp_swing),
      .rsp_midpoint      (rsp_midpoint),
      .rsp_valley_seen   (rsp_valley_seen),
      .rsp_peak_seen     (rsp_peak_seen)
   );

   always #5 clock = ~clock;

   // Predicted meter state
   int              prev_val;
   int              prev_prev_val;
   bit              peak_armed;
   bit              valley_armed;
   logic [TIME_W-1:0] period_origin_ms;
   logic [RATE_W-1:0] rate_hist [HISTORY_DEPTH];
   logic [RATE_W-1:0] cur_rate;
   logic [RATE_W-1:0] cur_mean;
   int              valley_level;
   int              cur_swing;
   int              cur_midpoint;

   meter_result_type pending_results[$];
   int              error_count = 0;
   bit              idle_on = 1'b1;
   int              stall_left = 0;
   logic [TIME_W-1:0] now_ms;
   int              last_sent;

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic void clear_meter();
      prev_val = 0;
      prev_prev_val = 0;
      peak_armed = 1'b0;
      valley_armed = 1'b0;
      period_origin_ms = '0;
      foreach (rate_hist[i]) rate_hist[i] = '0;
      cur_rate = '0;
      cur_mean = '0;
      valley_level = 0;
      cur_swing = 0;
      cur_midpoint = 0;
   endfunction

   // Advance the predicted meter by one sample and queue the result it yields.
   function automatic void predict_meter(input logic signed [SAMPLE_W-1:0] s,
                                         input logic [TIME_W-1:0] t);
      int                x;
      int                d_now;
      int                d_before;
      bit                valley;
      bit                peak;
      logic [TIME_W-1:0] period;
      logic [31:0]       hist_sum;
      meter_result_type  r;
      x = s;
      d_now = x - prev_val;
      d_before = prev_val - prev_prev_val;
      valley = (d_now > 0) && (d_before <= 0);
      peak = (d_now < 0) && (d_before >= 0);
      if (valley) begin
         if (peak_armed) begin
            period = t - period_origin_ms;
            if (period == 0) period = 1;
            cur_rate = RATE_W'(32'd60000 / period);
            for (int i = HISTORY_DEPTH - 1; i > 0; i--) rate_hist[i] = rate_hist[i-1];
            rate_hist[0] = cur_rate;
            hist_sum = 0;
            foreach (rate_hist[i]) hist_sum += rate_hist[i];
            cur_mean = RATE_W'(hist_sum / HISTORY_DEPTH);
            peak_armed = 1'b0;
            period_origin_ms = t;
         end
         valley_level = prev_val;
         valley_armed = 1'b1;
      end
      if (peak) begin
         peak_armed = 1'b1;
         if (valley_armed) begin
            cur_swing = prev_val - valley_level;
            cur_midpoint = (prev_val + valley_level) / 2;
            valley_armed = 1'b0;
         end
      end
      prev_prev_val = prev_val;
      prev_val = x;
      r.rate = cur_rate;
      r.mean = cur_mean;
      r.swing = SWING_W'(cur_swing);
      r.midpoint = SAMPLE_W'(cur_midpoint);
      r.valley = valley;
      r.peak = peak;
      pending_results.push_back(r);
   endfunction

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Send one beat; returns in the time step of the edge that accepted it.
   task automatic send_sample(input int s, input logic [TIME_W-1:0] t);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= SAMPLE_W'(s);
      req_time_ms <= t;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_meter(SAMPLE_W'(s), t);
      last_sent = s;
   endtask

   // Result check and downstream stall generation
   always @(posedge clock) begin : result_check
      meter_result_type want;
      int               r;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_results.size() == 0) begin
            report_error("result beat with nothing expected");
         end else begin
            want = pending_results.pop_front();
            if (rsp_rate_bpm !== want.rate)
               report_error($sformatf("rate_bpm got %0d want %0d", rsp_rate_bpm, want.rate));
            if (rsp_mean_rate_bpm !== want.mean)
               report_error($sformatf("mean_rate_bpm got %0d want %0d",
                                      rsp_mean_rate_bpm, want.mean));
            if (rsp_swing !== want.swing)
               report_error($sformatf("swing got %0d want %0d", rsp_swing, want.swing));
            if (rsp_midpoint !== want.midpoint)
               report_error($sformatf("midpoint got %0d want %0d", rsp_midpoint,
                                      want.midpoint));
            if (rsp_valley_seen !== want.valley)
               report_error($sformatf("valley_seen got %b want %b", rsp_valley_seen,
                                      want.valley));
            if (rsp_peak_seen !== want.peak)
               report_error($sformatf("peak_seen got %b want %b", rsp_peak_seen, want.peak));
         end
      end
      if (!idle_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            rsp_stall <= 1'b0;
         end else if (r < 92) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            stall_left = $urandom_range(8, 40);
            rsp_stall <= 1'b1;
         end
      end
   end

   // Peak before any valley, first period from time zero, full-scale swing.
   task automatic test_startup_events();
      send_sample(-32768, 5);
      send_sample(32767, 10);
      send_sample(32767, 20);
      send_sample(-32768, 30);
      send_sample(-32768, 30);
      send_sample(0, 30);
   endtask

   // Valley at the same ms as the period start, then midpoint truncation
   // toward zero on a negative sum.
   task automatic test_zero_period();
      send_sample(100, 30);
      send_sample(50, 30);
      send_sample(60, 30);
      send_sample(0, 31);
      send_sample(-3, 31);
      send_sample(0, 32);
      send_sample(-1, 33);
   endtask

   // Period across the 2^32 wrap, a period of exactly one minute and one
   // just beyond it.
   task automatic test_timestamp_wrap();
      send_sample(5, 32'hFFFF_FFF0);
      send_sample(2, 32'hFFFF_FFF8);
      send_sample(4, 32'h0000_0010);
      send_sample(1, 32'h0000_0011);
      send_sample(3, 32'h0000_EA70);
      send_sample(0, 32'd120000);
      send_sample(2, 32'd120017);
   endtask

   // Triangle-shaped pulse trains with random amplitude, offset, width and
   // sample spacing; timestamps jump now and then to reach every bit and wrap.
   task automatic test_pulse_trains(input int n_items);
      int sent;
      int amp;
      int offset;
      int half;
      int dt;
      int cycles;
      int level;
      int v;
      sent = 0;
      while (sent < n_items) begin
         idle_on = ($urandom_range(0, 4) != 0);
         amp = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 50) : $urandom_range(1, 32767);
         offset = $urandom_range(0, 2 * (32767 - amp)) - (32767 - amp);
         half = $urandom_range(1, 12);
         dt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 25);
         cycles = $urandom_range(1, 6);
         case ($urandom_range(0, 9))
            0: now_ms = $urandom();
            1: now_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
            default: ;
         endcase
         for (int c = 0; c < cycles; c++) begin
            for (int k = 0; k < 2 * half; k++) begin
               level = (k < half) ? k : 2 * half - k;
               v = offset - amp + (2 * amp * level) / half;
               if ($urandom_range(0, 7) == 0) v += $urandom_range(0, 8) - 4;
               if (v > 32767) v = 32767;
               if (v < -32768) v = -32768;
               now_ms += dt;
               send_sample(v, now_ms);
               sent++;
            end
         end
      end
      idle_on = 1'b1;
   endtask

   // Full-range noise, plateaus and small wiggles that break the pulse shape.
   task automatic test_noise(input int n_items);
      int r;
      int v;
      for (int i = 0; i < n_items; i++) begin
         r = $urandom_range(0, 9);
         if (r < 5)
            v = $signed(16'($urandom()));
         else if (r < 8)
            v = last_sent;
         else
            v = last_sent + $urandom_range(0, 6) - 3;
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         if ($urandom_range(0, 2) == 0) now_ms = $urandom();
         else now_ms += $urandom_range(0, 3);
         send_sample(v, now_ms);
      end
   endtask

   initial begin
      int waited;
      clear_meter();
      now_ms = '0;
      last_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_startup_events();
      test_zero_period();
      test_timestamp_wrap();
      now_ms = 32'd200000;
      test_pulse_trains(520);
      test_noise(110);
      req_valid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (60) @(posedge clock);
      if (pending_results.size() != 0)
         report_error($sformatf("%0d results never arrived", pending_results.size()));
      if (error_count == 0)
         $display("PASS pulse_peak_valley_rate_meter_unit");
      else
         $display("FAIL pulse_peak_valley_rate_meter_unit");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL pulse_peak_valley_rate_meter_unit");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/ppvrm_pkg.sv
hw/rtl/ppvrm_div.sv
hw/rtl/ppvrm_dp.sv
hw/rtl/ppvrm_ctrl.sv
hw/rtl/pulse_peak_valley_rate_meter_unit.sv
hw/rtl/ppvrm_checker.sv
tb/tb_pulse_peak_valley_rate_meter_unit.sv
